FILE: rtl/core/led_scn_pkg.sv
package led_scn_pkg;

	// Default number of scanned LED columns
	localparam int NUM_LEDS_DEF = 5;

	// Fixed field widths
	localparam int TIME_W   = 32;
	localparam int SENSOR_W = 10;
	localparam int LEVEL_W  = 8;
	localparam int MASK_W   = 5;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int PERIOD_W = 5;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_STEP = 2'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] INTERVAL_RST = 8'd1;
	localparam logic [CFG_W-1:0] FRAMES_RST   = 8'd15;

	// Colour map breakpoints
	localparam logic [SENSOR_W-1:0] GREEN_KNEE = 10'd100;
	localparam logic [SENSOR_W-1:0] BLUE_START = 10'd150;
	localparam logic [SENSOR_W-1:0] BLUE_END   = 10'd255;
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = 5'd20;

	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic [SENSOR_W-1:0] sensor;
	} in_item_t;

	typedef struct packed {
		logic [MASK_W-1:0]  column_off_mask;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
	} out_item_t;

	// Green/blue pair of one column
	typedef struct packed {
		logic [LEVEL_W-1:0] green;
		logic [LEVEL_W-1:0] blue;
	} levels_t;

	// Scanner positions, for checking at the top level
	typedef struct packed {
		logic [3:0] driven_column;
		logic [3:0] lit_position;
	} scan_status_t;

endpackage

FILE: rtl/core/led_scn_sense.sv
module led_scn_sense
	import led_scn_pkg::*;
(
	input  logic [SENSOR_W-1:0] sensor,
	output logic [PERIOD_W-1:0] period,
	output levels_t             levels
);

	// Frame period: 20 - floor(sensor*17/1023)
	logic [14:0] p_x;
	logic [4:0]  p_q0;
	logic [10:0] p_r;
	logic [4:0]  p_q;

	always_comb begin
		p_x = {1'b0, sensor, 4'b0000} + {5'b00000, sensor};
		p_q0 = p_x[14:10];
		// x - q0*1023 = low bits plus q0, always below twice the divisor
		p_r = {1'b0, p_x[9:0]} + {6'b000000, p_q0};
		p_q = p_q0 + {4'b0000, (p_r >= 11'd1023)};
		period = PERIOD_MAX - p_q;
	end

	// Green: floor(sensor*255/100), saturating above the knee
	logic [6:0]  g_s;
	logic [14:0] g_x;
	logic [24:0] g_prod;
	logic [7:0]  g_q0;
	logic [14:0] g_r;
	logic [LEVEL_W-1:0] green_lv;

	always_comb begin
		g_s = sensor[6:0];
		g_x = {g_s, 8'h00} - {8'h00, g_s};
		// reciprocal of 100, low by at most one
		g_prod = 25'(g_x) * 25'd655;
		g_q0 = g_prod[23:16];
		g_r = g_x - 15'(g_q0 * 15'd100);
		if (sensor > GREEN_KNEE) begin
			green_lv = 8'hFF;
		end else begin
			green_lv = g_q0 + {7'b0, (g_r >= 15'd100)};
		end
	end

	// Blue: 255 below the start, linear drop to zero at the end
	logic [6:0]  b_d;
	logic [14:0] b_x;
	logic [24:0] b_prod;
	logic [7:0]  b_q0;
	logic [14:0] b_r;
	logic [7:0]  b_q;
	logic [LEVEL_W-1:0] blue_lv;

	always_comb begin
		b_d = 7'(sensor - BLUE_START);
		b_x = {b_d, 8'h00} - {8'h00, b_d};
		// reciprocal of 105, low by at most one
		b_prod = 25'(b_x) * 25'd624;
		b_q0 = b_prod[23:16];
		b_r = b_x - 15'(b_q0 * 15'd105);
		b_q = b_q0 + {7'b0, (b_r >= 15'd105)};
		if (sensor < BLUE_START) begin
			blue_lv = 8'hFF;
		end else if (sensor >= BLUE_END) begin
			blue_lv = 8'h00;
		end else begin
			blue_lv = 8'hFF - b_q;
		end
	end

	assign levels = {green_lv, blue_lv};

endmodule

FILE: rtl/core/led_scn_core.sv
module led_scn_core
	import led_scn_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step_en,
	input  in_item_t            item,
	input  logic [PERIOD_W-1:0] period,
	input  levels_t             lit_levels,
	input  logic [CFG_W-1:0]    interval_ms,
	input  logic [CFG_W-1:0]    frames_per_step,
	output out_item_t           result,
	output scan_status_t        status
);

	localparam int POS_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_LEDS - 1);
	localparam logic [POS_W-1:0] TURN_POS = POS_W'(NUM_LEDS - 2);

	logic [POS_W-1:0]  lit_pos_q;
	logic              moving_up_q;
	logic [CFG_W-1:0]  frame_cnt_q;
	logic [POS_W-1:0]  driven_q;
	logic              pending_q;
	logic [TIME_W-1:0] last_col_q;
	logic [TIME_W-1:0] last_frame_q;
	levels_t           lit_color_q;
	levels_t           held_levels_q;
	logic [MASK_W-1:0] held_mask_q;

	logic [TIME_W-1:0] frame_elapsed;
	logic [TIME_W-1:0] col_elapsed;
	logic              frame_hit;
	logic              step_hit;
	logic              col_hit;
	logic [CFG_W-1:0]  cnt_inc;
	logic [CFG_W-1:0]  frame_cnt_n;
	logic [POS_W-1:0]  lit_pos_n;
	logic              moving_up_n;
	levels_t           lit_color_n;
	levels_t           held_levels_n;
	logic [MASK_W-1:0] held_mask_n;
	logic [POS_W-1:0]  driven_n;

	// Frame timing and bounce of the lit position
	always_comb begin
		frame_elapsed = item.now_ms - last_frame_q;
		frame_hit = frame_elapsed > {27'b0, period};
		cnt_inc = frame_cnt_q + 8'd1;
		step_hit = frame_hit && (cnt_inc >= frames_per_step);
		frame_cnt_n = frame_cnt_q;
		lit_pos_n = lit_pos_q;
		moving_up_n = moving_up_q;
		lit_color_n = lit_color_q;
		if (frame_hit) begin
			frame_cnt_n = cnt_inc;
		end
		if (step_hit) begin
			frame_cnt_n = '0;
			lit_color_n = lit_levels;
			if (moving_up_q) begin
				if (lit_pos_q == LAST_POS) begin
					lit_pos_n = TURN_POS;
					moving_up_n = 1'b0;
				end else begin
					lit_pos_n = lit_pos_q + POS_W'(1);
				end
			end else begin
				if (lit_pos_q == '0) begin
					lit_pos_n = POS_W'(1);
					moving_up_n = 1'b1;
				end else begin
					lit_pos_n = lit_pos_q - POS_W'(1);
				end
			end
		end
	end

	// Column drive: latch the pending column, then check its interval
	always_comb begin
		col_elapsed = item.now_ms - last_col_q;
		col_hit = col_elapsed > {24'b0, interval_ms};
		held_levels_n = held_levels_q;
		held_mask_n = held_mask_q;
		driven_n = driven_q;
		if (pending_q) begin
			held_levels_n = (driven_q == lit_pos_n) ? lit_color_n : '0;
			for (int j = 0; j < MASK_W; j++) begin
				held_mask_n[j] = (int'(driven_q) != j);
			end
		end
		if (col_hit) begin
			driven_n = (driven_q == LAST_POS) ? '0 : driven_q + POS_W'(1);
			held_mask_n = '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_pos_q <= '0;
			moving_up_q <= 1'b1;
			frame_cnt_q <= '0;
			driven_q <= '0;
			pending_q <= 1'b1;
			last_col_q <= '0;
			last_frame_q <= '0;
			lit_color_q <= '0;
			held_levels_q <= '0;
			held_mask_q <= '1;
		end else if (step_en) begin
			lit_pos_q <= lit_pos_n;
			moving_up_q <= moving_up_n;
			frame_cnt_q <= frame_cnt_n;
			driven_q <= driven_n;
			lit_color_q <= lit_color_n;
			held_levels_q <= held_levels_n;
			held_mask_q <= held_mask_n;
			pending_q <= col_hit;
			if (frame_hit) begin
				last_frame_q <= item.now_ms;
			end
			if (col_hit) begin
				last_col_q <= item.now_ms;
			end
		end
	end

	assign result.column_off_mask = held_mask_n;
	assign result.green_level = held_levels_n.green;
	assign result.blue_level = held_levels_n.blue;
	assign status.driven_column = 4'(driven_q);
	assign status.lit_position = 4'(lit_pos_q);

endmodule

FILE: rtl/core/led_scanner_mux_driver_unit.sv
// Larson scanner with time-multiplexed LED column drive.
// An accepted item passes through the input register, then the result register;
// the scanner state updates as the result register loads. Throughput: one item per
// cycle unless out_stall holds a result, set by the single-pass update in between.
// Reset (arst_n low, asynchronous): registers to 1 and 15, scanner at position 0,
// moving up, all columns off, no item held.
module led_scanner_mux_driver_unit
	import led_scn_pkg::*;
#(
	parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0]    interval_q;
	logic [CFG_W-1:0]    frames_q;
	logic                valid_s1;
	in_item_t            item_s1;
	logic                move;
	logic [PERIOD_W-1:0] period;
	levels_t             lit_levels;
	out_item_t           result;
	scan_status_t        status;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= INTERVAL_RST;
			frames_q <= FRAMES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_INTERVAL_MS:     interval_q <= cfg_data;
				CFG_FRAMES_PER_STEP: frames_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake: the item in s1 moves on whenever the result slot frees up
	assign move = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !move;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (move) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
		if (move) begin
			out_item <= result;
		end
	end

	led_scn_sense u_sense (
		.sensor (item_s1.sensor),
		.period (period),
		.levels (lit_levels)
	);

	led_scn_core #(
		.NUM_LEDS (NUM_LEDS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.step_en         (move),
		.item            (item_s1),
		.period          (period),
		.lit_levels      (lit_levels),
		.interval_ms     (interval_q),
		.frames_per_step (frames_q),
		.result          (result),
		.status          (status)
	);

	// Checks
	a_one_column_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($countones(~out_item.column_off_mask) <= 1))
		else $error("more than one column driven");

	a_stall_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a held item");

	a_driven_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(status.driven_column) < NUM_LEDS)
		else $error("driven column out of range");

	a_lit_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(status.lit_position) < NUM_LEDS)
		else $error("lit position out of range");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		move |=> out_valid)
		else $error("moved item did not reach the result register");

endmodule
